// ===== src/dbsr_pkg.sv =====
// Package for the door bus slave responder: codes, constants and the reply CRC step.
`default_nettype none
package dbsr_pkg;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_FRAME      = 2'd0,
    CMD_SET_ACTION = 2'd1,
    CMD_CLEAR      = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MASTER_ADDR  = 3'd0,
    CFG_OWN_ADDR     = 3'd1,
    CFG_BCAST_ADDR   = 3'd2,
    CFG_SCAN_CMD     = 3'd3,
    CFG_STREQ_CMD    = 3'd4,
    CFG_STRSP_CMD    = 3'd5,
    CFG_DEVICE_TYPE  = 3'd6,
    CFG_CRC_SEED     = 3'd7
  } cfg_idx_t;

  typedef logic [7:0] byte_t;

  localparam logic [3:0] BROADCAST_LEN = 4'd2;
  localparam logic [3:0] REQUEST_LEN   = 4'd1;
  localparam byte_t      IDLE_CODE     = 8'h00;
  localparam byte_t      CRC_POLY      = 8'h07;
  localparam logic [3:0] SCAN_TAG      = 4'h2;
  localparam logic [3:0] STATUS_TAG    = 4'h3;
  localparam byte_t      ACTION_TRAIL  = 8'h10;

  // Reply sizes in bytes (CRC included)
  localparam int unsigned SCAN_BYTES   = 5;
  localparam int unsigned STATUS_BYTES = 6;
  localparam int unsigned MAX_BYTES    = 6;
  localparam int unsigned IDX_W        = $clog2(MAX_BYTES);

  // Reset values of the configuration registers
  localparam byte_t RST_MASTER_ADDR = 8'd0;
  localparam byte_t RST_OWN_ADDR    = 8'd40;
  localparam byte_t RST_BCAST_ADDR  = 8'd0;
  localparam byte_t RST_SCAN_CMD    = 8'd1;
  localparam byte_t RST_STREQ_CMD   = 8'd32;
  localparam byte_t RST_STRSP_CMD   = 8'd41;
  localparam byte_t RST_DEVICE_TYPE = 8'd20;
  localparam byte_t RST_CRC_SEED    = 8'd243;

  // One byte through the CRC-8 register, MSB first
  function automatic byte_t crc8_byte(input byte_t crc_in, input byte_t data);
    byte_t c;
    c = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/door_bus_slave_responder.sv =====
// Top level of the door bus slave responder: frame decode, state and reply serializer.
// An input item is registered, decoded in the cycle it leaves the input register and
// loaded into the reply serializer, which emits one result per cycle while out_stall is
// low: one item with tx_valid low for inputs that cause no reply, five for a scan reply and
// six for a status reply. The CRC is accumulated one byte per transfer as the reply goes out.
// A new item is taken every cycle while replies are one item long and out_stall is low;
// otherwise a new input waits in the input register until the serializer has sent the last
// result of the reply before. The status outputs show the state after the item being emitted.
`default_nettype none
module door_bus_slave_responder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write port
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [7:0]         cfg_wdata,
  // input channel
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [1:0]         in_command,
  input  wire logic [3:0]         in_frame_len,
  input  wire logic [7:0]         in_rx_byte0,
  input  wire logic [7:0]         in_rx_byte1,
  input  wire logic [7:0]         in_rx_byte2,
  input  wire logic [7:0]         in_rx_byte3,
  input  wire logic [7:0]         in_rx_byte4,
  input  wire logic [7:0]         in_action_code,
  input  wire logic               in_action_is_stop,
  input  wire logic [2:0]         in_clear_mask,
  // result channel
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [7:0]         out_tx_byte,
  output      logic               out_tx_valid,
  output      logic               out_last,
  output      logic [7:0]         out_door_status,
  output      logic               out_connected_flag,
  output      logic               out_scanning_flag,
  output      logic               out_broadcast_seen
);
  import dbsr_pkg::*;

  // configuration registers
  byte_t master_addr_r, own_addr_r, bcast_addr_r, scan_cmd_r;
  byte_t streq_cmd_r, strsp_cmd_r, device_type_r, crc_seed_r;

  // input register
  logic       s1_valid_r;
  cmd_t       s1_cmd_r;
  logic [3:0] s1_len_r;
  byte_t      s1_b0_r, s1_b1_r, s1_b2_r, s1_act_r;
  logic       s1_stop_r;
  logic [2:0] s1_mask_r;

  // block state
  byte_t door_status_r, door_status_nxt;
  byte_t pend_act_r, pend_act_nxt;
  logic  pend_stop_r, pend_stop_nxt;
  logic  connected_r, connected_nxt;
  logic  scanning_r, scanning_nxt;
  logic  bcast_r, bcast_nxt;

  // reply serializer
  logic             s2_valid_r;
  byte_t            tx_r [MAX_BYTES];
  byte_t            tx_nxt [MAX_BYTES];
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] num_r, num_nxt;
  logic             has_reply_r, has_reply_nxt;
  byte_t            crc_r;

  logic out_xfer, s2_free, s1_adv, in_xfer, is_last;

  assign is_last  = (idx_r == num_r - IDX_W'(1));
  assign out_xfer = s2_valid_r && !out_stall;
  assign s2_free  = !s2_valid_r || (out_xfer && is_last);
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_xfer  = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_addr_r <= RST_MASTER_ADDR;
      own_addr_r    <= RST_OWN_ADDR;
      bcast_addr_r  <= RST_BCAST_ADDR;
      scan_cmd_r    <= RST_SCAN_CMD;
      streq_cmd_r   <= RST_STREQ_CMD;
      strsp_cmd_r   <= RST_STRSP_CMD;
      device_type_r <= RST_DEVICE_TYPE;
      crc_seed_r    <= RST_CRC_SEED;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MASTER_ADDR: master_addr_r <= cfg_wdata;
        CFG_OWN_ADDR:    own_addr_r    <= cfg_wdata;
        CFG_BCAST_ADDR:  bcast_addr_r  <= cfg_wdata;
        CFG_SCAN_CMD:    scan_cmd_r    <= cfg_wdata;
        CFG_STREQ_CMD:   streq_cmd_r   <= cfg_wdata;
        CFG_STRSP_CMD:   strsp_cmd_r   <= cfg_wdata;
        CFG_DEVICE_TYPE: device_type_r <= cfg_wdata;
        CFG_CRC_SEED:    crc_seed_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_len_r  <= in_frame_len;
      s1_b0_r   <= in_rx_byte0;
      s1_b1_r   <= in_rx_byte1;
      s1_b2_r   <= in_rx_byte2;
      s1_act_r  <= in_action_code;
      s1_stop_r <= in_action_is_stop;
      s1_mask_r <= in_clear_mask;
    end
  end

  // decode: reply bytes and next state for the item in the input register
  logic [3:0] len_nib, cnt_nib;
  logic       len_ok, is_query, is_scan, is_streq, is_bcast;

  always_comb begin
    len_nib  = s1_b1_r[3:0];
    cnt_nib  = s1_b1_r[7:4] + 4'd1;
    len_ok   = (s1_len_r == 4'd4) || (s1_len_r == 4'd5);
    is_query = (s1_cmd_r == CMD_FRAME) && len_ok && (s1_b0_r == own_addr_r);
    is_scan  = is_query && (s1_len_r == 4'd5) && (len_nib == BROADCAST_LEN)
               && (s1_b2_r == scan_cmd_r);
    is_streq = is_query && (s1_len_r == 4'd4) && (len_nib == REQUEST_LEN)
               && (s1_b2_r == streq_cmd_r);
    is_bcast = (s1_cmd_r == CMD_FRAME) && !is_query && (s1_len_r == 4'd5)
               && (s1_b0_r == bcast_addr_r) && (len_nib == BROADCAST_LEN);

    door_status_nxt = door_status_r;
    pend_act_nxt    = pend_act_r;
    pend_stop_nxt   = pend_stop_r;
    connected_nxt   = connected_r;
    scanning_nxt    = scanning_r;
    bcast_nxt       = bcast_r;
    for (int i = 0; i < MAX_BYTES; i++) begin
      tx_nxt[i] = '0;
    end
    num_nxt       = IDX_W'(1);
    has_reply_nxt = 1'b0;

    case (s1_cmd_r)
      CMD_SET_ACTION: begin
        pend_act_nxt  = s1_act_r;
        pend_stop_nxt = s1_stop_r;
      end
      CMD_CLEAR: begin
        if (s1_mask_r[0]) bcast_nxt     = 1'b0;
        if (s1_mask_r[1]) connected_nxt = 1'b0;
        if (s1_mask_r[2]) scanning_nxt  = 1'b0;
      end
      CMD_FRAME: begin
        if (is_scan) begin
          tx_nxt[0]     = master_addr_r;
          tx_nxt[1]     = {cnt_nib, SCAN_TAG};
          tx_nxt[2]     = device_type_r;
          tx_nxt[3]     = own_addr_r;
          num_nxt       = IDX_W'(SCAN_BYTES);
          has_reply_nxt = 1'b1;
          scanning_nxt  = 1'b1;
        end else if (is_streq) begin
          tx_nxt[0]     = master_addr_r;
          tx_nxt[1]     = {cnt_nib, STATUS_TAG};
          tx_nxt[2]     = strsp_cmd_r;
          tx_nxt[3]     = pend_stop_r ? 8'h00 : pend_act_r;
          tx_nxt[4]     = pend_stop_r ? 8'h00 : ACTION_TRAIL;
          num_nxt       = IDX_W'(STATUS_BYTES);
          has_reply_nxt = 1'b1;
          pend_act_nxt  = IDLE_CODE;
          pend_stop_nxt = 1'b0;
          connected_nxt = 1'b1;
        end else if (is_bcast) begin
          door_status_nxt = s1_b2_r;
          bcast_nxt       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // block state, updated as an item moves into the serializer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_status_r <= '0;
      pend_act_r    <= IDLE_CODE;
      pend_stop_r   <= 1'b0;
      connected_r   <= 1'b0;
      scanning_r    <= 1'b0;
      bcast_r       <= 1'b0;
    end else if (s1_adv) begin
      door_status_r <= door_status_nxt;
      pend_act_r    <= pend_act_nxt;
      pend_stop_r   <= pend_stop_nxt;
      connected_r   <= connected_nxt;
      scanning_r    <= scanning_nxt;
      bcast_r       <= bcast_nxt;
    end
  end

  // serializer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      idx_r      <= '0;
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
      idx_r      <= '0;
    end else if (out_xfer) begin
      if (is_last) begin
        s2_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // serializer payload and running CRC
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
        tx_r[i] <= tx_nxt[i];
      end
      num_r       <= num_nxt;
      has_reply_r <= has_reply_nxt;
      crc_r       <= crc_seed_r;
    end else if (out_xfer && !is_last) begin
      crc_r <= crc8_byte(crc_r, tx_r[idx_r]);
    end
  end

  // result outputs
  assign out_valid          = s2_valid_r;
  assign out_tx_valid       = has_reply_r;
  assign out_last           = is_last;
  assign out_tx_byte        = !has_reply_r ? 8'h00 : (is_last ? crc_r : tx_r[idx_r]);
  assign out_door_status    = door_status_r;
  assign out_connected_flag = connected_r;
  assign out_scanning_flag  = scanning_r;
  assign out_broadcast_seen = bcast_r;

endmodule
`default_nettype wire

// ===== src/dbsr_checker.sv =====
// Port-level checker for the door bus slave responder, bound to the top level.
`default_nettype none
module dbsr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_tx_byte,
  input wire logic       out_tx_valid,
  input wire logic       out_last,
  input wire logic [7:0] out_door_status
);

  // an item without a reply byte is a single, final result carrying zero
  a_noreply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_last && (out_tx_byte == 8'h00))
    else $error("no-reply result not last or byte not zero");

  // a reply keeps going: after a non-final transfer the next reply byte is shown
  a_reply_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && out_tx_valid)
    else $error("reply frame interrupted");

  // the door status does not change in the middle of a reply frame
  a_status_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> $stable(out_door_status))
    else $error("door status changed within a reply");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind door_bus_slave_responder dbsr_checker u_dbsr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_tx_byte    (out_tx_byte),
  .out_tx_valid   (out_tx_valid),
  .out_last       (out_last),
  .out_door_status(out_door_status)
);
`default_nettype wire
